// ===== design/ovn_pkg.sv =====
package ovn_pkg;

  localparam int WIDTH       = 64;
  localparam int HEIGHT      = 64;
  localparam int MAX_OCTAVES = 7;

  localparam int XW        = $clog2(WIDTH);
  localparam int YW        = $clog2(HEIGHT);
  localparam int AW        = XW + YW;
  localparam int OCT_LIMIT = $clog2(WIDTH + 1);
  localparam int NOCT      = (MAX_OCTAVES < OCT_LIMIT) ? MAX_OCTAVES : OCT_LIMIT;
  localparam int KW        = (NOCT > 1) ? $clog2(NOCT) : 1;
  localparam int PW        = XW + 1;

  localparam int SEED_W    = 16;
  localparam int SCALE_W   = 32;
  localparam int BIAS_W    = 12;
  localparam int BIAS_FRAC = 8;
  localparam int OCW       = 3;
  localparam int CFG_W     = BIAS_W;
  localparam int DIVN_W    = SCALE_W + BIAS_FRAC;

  localparam int RW        = SEED_W + PW;
  localparam int TW        = SEED_W + 2 * XW + 1;
  localparam int SUM_W     = SCALE_W + $clog2(NOCT + 1);
  localparam int PROD_W    = SEED_W + SCALE_W;
  localparam int NUM_W     = PROD_W + $clog2(NOCT + 1);
  localparam int TREE_N    = 8;

  localparam int QB        = SEED_W;
  localparam int BPS       = 2;
  localparam int DIV_ST    = QB / BPS;

  localparam logic [OCW-1:0]     OC_RESET   = OCW'(5);
  localparam logic [BIAS_W-1:0]  BIAS_RESET = BIAS_W'(512);
  localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(65536);

  typedef enum logic [0:0] {
    CFG_OCTAVE_COUNT = 1'b0,
    CFG_BIAS         = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    logic             busy;
    logic [NOCT-1:0]  lane_en;
    logic [SUM_W-1:0] scale_sum;
  } scale_stat_t;

endpackage

// ===== design/ovn_ram.sv =====
module ovn_ram #(
  parameter int DW = 16,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/ovn_scale.sv =====
module ovn_scale (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we,
  input  ovn_pkg::cfg_idx_t                           cfg_index,
  input  logic [ovn_pkg::CFG_W-1:0]                   cfg_data,
  output logic [ovn_pkg::NOCT-1:0][ovn_pkg::SCALE_W-1:0] scale,
  output ovn_pkg::scale_stat_t                        stat
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_SUM = 3'b100
  } state_t;

  localparam int BCW = $clog2(ovn_pkg::DIVN_W);

  state_t                          state_r, state_nxt;
  logic [ovn_pkg::OCW-1:0]         oc_r, oc_nxt;
  logic [ovn_pkg::BIAS_W-1:0]      bias_r, bias_nxt;
  logic [ovn_pkg::KW-1:0]          k_r, k_nxt;
  logic [BCW-1:0]                  bit_r, bit_nxt;
  logic [ovn_pkg::DIVN_W-1:0]      num_r, num_nxt;
  logic [ovn_pkg::BIAS_W-1:0]      rem_r, rem_nxt;
  logic [ovn_pkg::DIVN_W-1:0]      quo_r, quo_nxt;
  logic [ovn_pkg::SCALE_W-1:0]     scale_r [ovn_pkg::NOCT];
  logic [ovn_pkg::SCALE_W-1:0]     scale_nxt [ovn_pkg::NOCT];
  logic [ovn_pkg::SUM_W-1:0]       sum_r, sum_nxt;

  logic [ovn_pkg::BIAS_W-1:0]      div;
  logic [ovn_pkg::BIAS_W:0]        trial;
  logic                            ge;
  logic [ovn_pkg::BIAS_W-1:0]      rem_step;
  logic [ovn_pkg::DIVN_W-1:0]      quo_step;
  logic [ovn_pkg::SCALE_W-1:0]     quo_sat;
  logic [ovn_pkg::OCW:0]           n_eff;
  logic [ovn_pkg::NOCT-1:0]        lane_en;

  always_comb begin
    div      = (bias_r == '0) ? ovn_pkg::BIAS_W'(1) : bias_r;
    trial    = {rem_r, num_r[ovn_pkg::DIVN_W-1]};
    ge       = trial >= {1'b0, div};
    rem_step = ge ? ovn_pkg::BIAS_W'(trial - {1'b0, div}) : trial[ovn_pkg::BIAS_W-1:0];
    quo_step = {quo_r[ovn_pkg::DIVN_W-2:0], ge};
    quo_sat  = (|quo_step[ovn_pkg::DIVN_W-1:ovn_pkg::SCALE_W]) ? '1
             : quo_step[ovn_pkg::SCALE_W-1:0];

    n_eff = (oc_r == '0) ? (ovn_pkg::OCW+1)'(1) : {1'b0, oc_r};
    if (n_eff > (ovn_pkg::OCW+1)'(ovn_pkg::NOCT)) begin
      n_eff = (ovn_pkg::OCW+1)'(ovn_pkg::NOCT);
    end
    for (int o = 0; o < ovn_pkg::NOCT; o++) begin
      lane_en[o] = (ovn_pkg::OCW+1)'(o) < n_eff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    oc_nxt    = oc_r;
    bias_nxt  = bias_r;
    k_nxt     = k_r;
    bit_nxt   = bit_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    scale_nxt = scale_r;
    sum_nxt   = sum_r;

    unique case (state_r)
      ST_DIV: begin
        rem_nxt = rem_step;
        num_nxt = num_r << 1;
        quo_nxt = quo_step;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BCW'(ovn_pkg::DIVN_W - 1)) begin
          scale_nxt[k_r] = quo_sat;
          bit_nxt = '0;
          rem_nxt = '0;
          quo_nxt = '0;
          num_nxt = {quo_sat, {ovn_pkg::BIAS_FRAC{1'b0}}};
          if (k_r == ovn_pkg::KW'(ovn_pkg::NOCT - 1)) begin
            state_nxt = ST_SUM;
            k_nxt     = '0;
            sum_nxt   = '0;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      ST_SUM: begin
        sum_nxt = sum_r + (lane_en[k_r] ? ovn_pkg::SUM_W'(scale_r[k_r]) : '0);
        if (k_r == ovn_pkg::KW'(ovn_pkg::NOCT - 1)) begin
          state_nxt = ST_RUN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_RUN: begin
      end
      default: begin
        state_nxt = ST_DIV;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        ovn_pkg::CFG_OCTAVE_COUNT: oc_nxt   = cfg_data[ovn_pkg::OCW-1:0];
        ovn_pkg::CFG_BIAS:         bias_nxt = cfg_data[ovn_pkg::BIAS_W-1:0];
        default: begin
        end
      endcase
      state_nxt = ST_DIV;
      k_nxt     = ovn_pkg::KW'(1);
      bit_nxt   = '0;
      rem_nxt   = '0;
      quo_nxt   = '0;
      num_nxt   = {scale_r[0], {ovn_pkg::BIAS_FRAC{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_DIV;
      oc_r       <= ovn_pkg::OC_RESET;
      bias_r     <= ovn_pkg::BIAS_RESET;
      k_r        <= ovn_pkg::KW'(1);
      bit_r      <= '0;
      num_r      <= {ovn_pkg::SCALE_ONE, {ovn_pkg::BIAS_FRAC{1'b0}}};
      rem_r      <= '0;
      quo_r      <= '0;
      sum_r      <= '0;
      scale_r[0] <= ovn_pkg::SCALE_ONE;
    end else begin
      state_r <= state_nxt;
      oc_r    <= oc_nxt;
      bias_r  <= bias_nxt;
      k_r     <= k_nxt;
      bit_r   <= bit_nxt;
      num_r   <= num_nxt;
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      sum_r   <= sum_nxt;
      scale_r <= scale_nxt;
    end
  end

  always_comb begin
    for (int o = 0; o < ovn_pkg::NOCT; o++) begin
      scale[o] = scale_r[o];
    end
    stat.busy      = state_r != ST_RUN;
    stat.lane_en   = lane_en;
    stat.scale_sum = sum_r;
  end

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> stat.busy)
    else $error("scale sequencer did not restart after a register write");

  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy && !cfg_we |=> $stable(sum_r))
    else $error("scale sum changed while the sequencer was idle");

  a_sum_min: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> sum_r >= ovn_pkg::SUM_W'(ovn_pkg::SCALE_ONE))
    else $error("scale sum is below the first octave scale");

  a_lane_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> k_r != '0)
    else $error("division started on the first octave");

endmodule

// ===== design/octave_value_noise_2d_unit.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_kind, in_seed_index, in_seed_value, in_x, in_y
// out     | output    | out_valid/out_stall | out_noise_value
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; a query's result passes through
// the four lane stages, the three-level octave sum, the 8-stage divider and the output register.
// A seed write takes effect at its transfer and gives no result.
// After reset and after every register write the scale sequencer holds in_stall high while
// it divides out each of the six scales after the first, bit by bit, and then steps through
// the seven octave lanes to sum the scales of the enabled ones.
// A stall on the result channel freezes the whole pipeline; nothing is lost or repeated.
module octave_value_noise_2d_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [ovn_pkg::AW-1:0]        in_seed_index,
  input  logic [ovn_pkg::SEED_W-1:0]    in_seed_value,
  input  logic [ovn_pkg::XW-1:0]        in_x,
  input  logic [ovn_pkg::YW-1:0]        in_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ovn_pkg::SEED_W-1:0]    out_noise_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ovn_pkg::cfg_idx_t             cfg_index,
  input  logic [ovn_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NOCT = ovn_pkg::NOCT;

  logic                                       adv;
  logic                                       in_xfer;
  logic                                       seed_we;
  logic [NOCT-1:0][ovn_pkg::SCALE_W-1:0]      scale;
  ovn_pkg::scale_stat_t                       stat;

  logic                                       v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [ovn_pkg::XW-1:0]                     x1_r;
  logic [ovn_pkg::YW-1:0]                     y1_r, y2_r;

  logic [ovn_pkg::SEED_W-1:0]                 sa [NOCT];
  logic [ovn_pkg::SEED_W-1:0]                 sb [NOCT];
  logic [ovn_pkg::SEED_W-1:0]                 sc [NOCT];
  logic [ovn_pkg::SEED_W-1:0]                 sd [NOCT];
  logic [ovn_pkg::RW-1:0]                     r1_r [NOCT];
  logic [ovn_pkg::RW-1:0]                     r2_r [NOCT];
  logic [ovn_pkg::SEED_W-1:0]                 smp_r [NOCT];
  logic [ovn_pkg::PROD_W-1:0]                 prod_r [NOCT];

  logic [ovn_pkg::NUM_W-1:0]                  leaf [ovn_pkg::TREE_N];
  logic [ovn_pkg::NUM_W-1:0]                  s4_r [4];
  logic [ovn_pkg::NUM_W-1:0]                  s2_r [2];
  logic [ovn_pkg::NUM_W-1:0]                  s1_r;

  logic [ovn_pkg::NUM_W-1:0]                  drem_r [ovn_pkg::DIV_ST];
  logic [ovn_pkg::QB-1:0]                     dq_r [ovn_pkg::DIV_ST];
  logic                                       dv_r [ovn_pkg::DIV_ST];

  logic                                       out_valid_r;
  logic [ovn_pkg::SEED_W-1:0]                 out_noise_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv || stat.busy;
  assign in_xfer   = in_valid && !in_stall;
  assign seed_we   = in_xfer && (in_kind == ovn_pkg::KIND_WRITE);
  assign cfg_ready = 1'b1;

  ovn_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scale     (scale),
    .stat      (stat)
  );

  for (genvar o = 0; o < NOCT; o++) begin : g_lane
    localparam int S = ovn_pkg::XW - o;
    localparam logic [ovn_pkg::XW-1:0] XLO   = ovn_pkg::XW'((1 << S) - 1);
    localparam logic [ovn_pkg::YW-1:0] YLO   = ovn_pkg::YW'((1 << S) - 1);
    localparam logic [ovn_pkg::PW-1:0] PITCH = ovn_pkg::PW'(1 << S);

    logic [ovn_pkg::XW-1:0] xa, xb;
    logic [ovn_pkg::YW-1:0] ya, yb;
    logic [ovn_pkg::PW-1:0] dx, pdx, dy, pdy;
    logic [ovn_pkg::TW-1:0] t;

    always_comb begin
      xa  = in_x & ~XLO;
      xb  = xa + ovn_pkg::XW'(1 << S);
      ya  = in_y & ~YLO;
      yb  = ya + ovn_pkg::YW'(1 << S);
      dx  = ovn_pkg::PW'(x1_r & XLO);
      pdx = PITCH - dx;
      dy  = ovn_pkg::PW'(y2_r & YLO);
      pdy = PITCH - dy;
      t   = ovn_pkg::TW'(pdy) * ovn_pkg::TW'(r1_r[o])
          + ovn_pkg::TW'(dy) * ovn_pkg::TW'(r2_r[o]);
    end

    ovn_ram #(.DW(ovn_pkg::SEED_W), .AW(ovn_pkg::AW)) u_ram_top (
      .clk     (clk),
      .we      (seed_we),
      .waddr   (in_seed_index),
      .wdata   (in_seed_value),
      .re      (adv),
      .raddr_a ({ya, xa}),
      .raddr_b ({ya, xb}),
      .rdata_a (sa[o]),
      .rdata_b (sb[o])
    );

    ovn_ram #(.DW(ovn_pkg::SEED_W), .AW(ovn_pkg::AW)) u_ram_bot (
      .clk     (clk),
      .we      (seed_we),
      .waddr   (in_seed_index),
      .wdata   (in_seed_value),
      .re      (adv),
      .raddr_a ({yb, xa}),
      .raddr_b ({yb, xb}),
      .rdata_a (sc[o]),
      .rdata_b (sd[o])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        r1_r[o]   <= ovn_pkg::RW'(pdx) * ovn_pkg::RW'(sa[o])
                   + ovn_pkg::RW'(dx) * ovn_pkg::RW'(sb[o]);
        r2_r[o]   <= ovn_pkg::RW'(pdx) * ovn_pkg::RW'(sc[o])
                   + ovn_pkg::RW'(dx) * ovn_pkg::RW'(sd[o]);
        smp_r[o]  <= ovn_pkg::SEED_W'(t >> (2 * S));
        prod_r[o] <= stat.lane_en[o]
                   ? ovn_pkg::PROD_W'(smp_r[o]) * ovn_pkg::PROD_W'(scale[o]) : '0;
      end
    end
  end

  for (genvar i = 0; i < ovn_pkg::TREE_N; i++) begin : g_leaf
    if (i < NOCT) begin : g_used
      assign leaf[i] = ovn_pkg::NUM_W'(prod_r[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar j = 0; j < ovn_pkg::DIV_ST; j++) begin : g_div
    logic [ovn_pkg::NUM_W-1:0] rem_in, rem_out, shd;
    logic [ovn_pkg::QB-1:0]    q_in, q_out;
    logic                      v_in;

    if (j == 0) begin : g_first
      assign rem_in = s1_r;
      assign q_in   = '0;
      assign v_in   = v7_r;
    end else begin : g_next
      assign rem_in = drem_r[j-1];
      assign q_in   = dq_r[j-1];
      assign v_in   = dv_r[j-1];
    end

    always_comb begin
      rem_out = rem_in;
      q_out   = q_in;
      shd     = '0;
      for (int b = 0; b < ovn_pkg::BPS; b++) begin
        shd = ovn_pkg::NUM_W'(stat.scale_sum) << (ovn_pkg::QB - 1 - ovn_pkg::BPS * j - b);
        if (rem_out >= shd) begin
          rem_out = rem_out - shd;
          q_out[ovn_pkg::QB - 1 - ovn_pkg::BPS * j - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[j] <= rem_out;
        dq_r[j]   <= q_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_xfer && (in_kind == ovn_pkg::KIND_QUERY);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= dv_r[ovn_pkg::DIV_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= in_x;
      y1_r <= in_y;
      y2_r <= y1_r;
      for (int i = 0; i < 4; i++) begin
        s4_r[i] <= leaf[2*i] + leaf[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
        s2_r[i] <= s4_r[2*i] + s4_r[2*i+1];
      end
      s1_r        <= s2_r[0] + s2_r[1];
      out_noise_r <= dq_r[ovn_pkg::DIV_ST-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("stalled result did not hold");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> in_stall)
    else $error("input open while the scale sequencer runs");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall) || stat.busy)
    else $error("input stalled without a cause");

endmodule
